[rtl/brq_pkg.sv]
// ----------------------------------------------------------------------------
// brq_pkg
// shared types and constants of the byte/5-bit symbol regrouper
// ----------------------------------------------------------------------------
`default_nettype none

package brq_pkg;

    localparam int BYTE_W          = 8;
    localparam int SYM_W           = 5;
    localparam int BLOCK_W         = 40;
    localparam int SYMS_PER_BLOCK  = 8;
    localparam int BYTES_PER_BLOCK = 5;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CNT_W           = 3;
    localparam int RUN_W           = 4;

    typedef enum logic [1:0] {
        JOB_PACK   = 2'd0,
        JOB_UNPACK = 2'd1,
        JOB_ERROR  = 2'd2
    } job_kind_t;

    typedef enum logic {
        DIR_PACK   = 1'b0,
        DIR_UNPACK = 1'b1
    } dir_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] block;
        job_kind_t          kind;
        logic               eos;
    } job_t;

endpackage

`default_nettype wire

[rtl/brq_front.sv]
// ----------------------------------------------------------------------------
// brq_front
// accepts input items, collects a 40-bit block and hands finished blocks
// (or a length error) to the job queue
// ----------------------------------------------------------------------------
`default_nettype none

module brq_front
    import brq_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,
    input  wire logic              in_valid,
    input  wire logic [BYTE_W-1:0] in_value,
    input  wire logic              in_eos,
    output logic                   in_ready,
    input  wire logic              q_full,
    output logic                   push,
    output job_t                   push_job
);

    dir_t               dir_reg,   dir_next;
    logic [BLOCK_W-1:0] acc_reg,   acc_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;

    logic [BLOCK_W-1:0] acc_shifted;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W-1:0]   pad_syms;
    logic [5:0]         pad_bits;
    logic               accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign pad_syms = CNT_W'(0) - cnt_inc;
    assign pad_bits = 6'(pad_syms) * 6'(SYM_W);

    always_comb begin
        acc_shifted = (dir_reg == DIR_UNPACK)
                    ? {acc_reg[BLOCK_W-SYM_W-1:0], in_value[SYM_W-1:0]}
                    : {acc_reg[BLOCK_W-BYTE_W-1:0], in_value};
        dir_next       = dir_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        push           = 1'b0;
        push_job.block = acc_shifted;
        push_job.kind  = JOB_PACK;
        push_job.eos   = in_eos;

        if (cfg_wr_en) begin
            dir_next = dir_t'(cfg_wr_data);
            acc_next = '0;
            cnt_next = '0;
        end else if (accept) begin
            acc_next = acc_shifted;
            cnt_next = cnt_inc;
            if (dir_reg == DIR_PACK) begin
                if (cnt_inc == CNT_W'(BYTES_PER_BLOCK)) begin
                    push     = 1'b1;
                    acc_next = '0;
                    cnt_next = '0;
                end else if (in_eos) begin
                    push           = 1'b1;
                    push_job.kind  = JOB_ERROR;
                    push_job.block = '0;
                    acc_next       = '0;
                    cnt_next       = '0;
                end
            end else begin
                if (cnt_inc == '0 || in_eos) begin
                    push           = 1'b1;
                    push_job.kind  = JOB_UNPACK;
                    push_job.block = acc_shifted << pad_bits;
                    acc_next       = '0;
                    cnt_next       = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= DIR_PACK;
            acc_reg <= '0;
            cnt_reg <= '0;
        end else begin
            dir_reg <= dir_next;
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    a_pack_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (dir_reg == DIR_PACK) |-> (cnt_reg < CNT_W'(BYTES_PER_BLOCK)))
        else $error("pack block count beyond block size");

endmodule

`default_nettype wire

[rtl/brq_queue.sv]
// ----------------------------------------------------------------------------
// brq_queue
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module brq_queue
    import brq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output logic      full,
    output logic      head_valid,
    output job_t      head_job
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    job_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] count_reg,  count_next;

    assign full       = (count_reg == FILL_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + FILL_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full job queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> !pop)
        else $error("pop from empty job queue");

endmodule

`default_nettype wire

[rtl/brq_back.sv]
// ----------------------------------------------------------------------------
// brq_back
// takes jobs from the queue and emits their results one per cycle while tready
// is high, through a registered output stage
// ----------------------------------------------------------------------------
`default_nettype none

module brq_back
    import brq_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire job_t               q_job,
    output logic                    q_pop,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [BYTE_W-1:0]       m_axis_tdata,   // result_value
    output logic                    m_axis_tlast,   // run_last
    output logic [1:0]              m_axis_tuser    // stream_done, length_error
);

    logic               active_reg, active_next;
    logic [BLOCK_W-1:0] shift_reg,  shift_next;
    logic [RUN_W-1:0]   remain_reg, remain_next;
    job_kind_t          kind_reg,   kind_next;
    logic               eos_reg,    eos_next;

    logic               mvalid_reg, mvalid_next;
    logic [BYTE_W-1:0]  mdata_reg,  mdata_next;
    logic               mlast_reg,  mlast_next;
    logic [1:0]         muser_reg,  muser_next;

    logic               out_free;
    logic [BLOCK_W-1:0] cur_block;
    job_kind_t          cur_kind;
    logic               cur_eos;
    logic [RUN_W-1:0]   cur_cnt;
    logic [RUN_W-1:0]   job_total;
    logic               cur_final;

    assign out_free = !mvalid_reg || m_axis_tready;

    always_comb begin
        case (q_job.kind)
            JOB_PACK:   job_total = RUN_W'(SYMS_PER_BLOCK);
            JOB_UNPACK: job_total = RUN_W'(BYTES_PER_BLOCK);
            default:    job_total = RUN_W'(1);
        endcase
    end

    always_comb begin
        cur_block = active_reg ? shift_reg  : q_job.block;
        cur_kind  = active_reg ? kind_reg   : q_job.kind;
        cur_eos   = active_reg ? eos_reg    : q_job.eos;
        cur_cnt   = active_reg ? remain_reg : job_total;
        cur_final = (cur_cnt == RUN_W'(1));

        active_next = active_reg;
        shift_next  = shift_reg;
        remain_next = remain_reg;
        kind_next   = kind_reg;
        eos_next    = eos_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;
        muser_next  = muser_reg;
        q_pop       = 1'b0;

        if (out_free) begin
            mvalid_next = 1'b0;
            if (active_reg || q_valid) begin
                q_pop       = !active_reg;
                mvalid_next = 1'b1;
                mlast_next  = cur_final;
                muser_next  = {cur_kind == JOB_ERROR, cur_eos && cur_final};
                kind_next   = cur_kind;
                eos_next    = cur_eos;
                remain_next = cur_cnt - RUN_W'(1);
                active_next = !cur_final;
                case (cur_kind)
                    JOB_PACK: begin
                        mdata_next = BYTE_W'(cur_block[BLOCK_W-1 -: SYM_W]);
                        shift_next = cur_block << SYM_W;
                    end
                    JOB_UNPACK: begin
                        mdata_next = cur_block[BLOCK_W-1 -: BYTE_W];
                        shift_next = cur_block << BYTE_W;
                    end
                    default: begin
                        mdata_next = '0;
                        shift_next = cur_block;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg  <= shift_next;
        remain_reg <= remain_next;
        kind_reg   <= kind_next;
        eos_reg    <= eos_next;
        mdata_reg  <= mdata_next;
        mlast_reg  <= mlast_next;
        muser_reg  <= muser_next;
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tlast  = mlast_reg;
    assign m_axis_tuser  = muser_reg;

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && muser_reg[1]) |-> (mlast_reg && muser_reg[0] && mdata_reg == '0))
        else $error("length error transaction not a lone final zero result");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && muser_reg[0]) |-> (mlast_reg && !active_reg))
        else $error("stream end flagged before the end of a run");

endmodule

`default_nettype wire

[rtl/byte_quint_regrouper.sv]
// a completed block enters the job queue; its first result then loads the output register
// throughput: one input and one result per cycle while queue has room and tready is high
// pack mode is limited by the single result port: 5 input bytes give 8 results
// unpack mode sustains one input symbol per cycle while tready is high (5 results per 8 symbols)
// reset (aresetn low, synchronous): direction returns to pack, block, queue and output cleared
// ----------------------------------------------------------------------------
// byte_quint_regrouper
// regroups a stream between bytes and 5-bit symbols, msb first, in 40-bit blocks
// ----------------------------------------------------------------------------
`default_nettype none

module byte_quint_regrouper
    import brq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [BYTE_W-1:0] s_axis_tdata,    // value
    input  wire logic              s_axis_tlast,    // end_of_stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [BYTE_W-1:0]      m_axis_tdata,    // result_value
    output logic                   m_axis_tlast,    // run_last
    output logic [1:0]             m_axis_tuser     // stream_done, length_error
);

    logic push;
    job_t push_job;
    logic q_full;
    logic q_pop;
    logic q_valid;
    job_t q_job;

    brq_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_value    (s_axis_tdata),
        .in_eos      (s_axis_tlast),
        .in_ready    (s_axis_tready),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    brq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_job   (q_job)
    );

    brq_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_job         (q_job),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

[verif/byte_quint_regrouper_test.sv]
// ----------------------------------------------------------------------------
// byte_quint_regrouper_test
// Self-checking bench for the byte / 5-bit symbol regrouper. A short table of
// directed streams covers both directions, field extremes, length errors and
// the padding of partial symbol blocks. Random streams follow, mostly well
// formed with random content. A scoreboard predicts every result and compares
// it field by field while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module byte_quint_regrouper_test;
    timeunit 1ns;
    timeprecision 1ps;

    import brq_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              done;
        logic              err;
    } regroup_t;

    typedef struct packed {
        bit                wr_dir;
        logic [BYTE_W-1:0] value;
        logic              eos;
        bit                typed;
        regroup_t          want;
    } stim_row_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    localparam int PLAN_N      = 26;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 65;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;

    logic              aclk;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic              cfg_wr_data   = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata  = '0;   // value
    logic              s_axis_tlast  = 1'b0; // end_of_stream
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [BYTE_W-1:0] m_axis_tdata;         // result_value
    logic              m_axis_tlast;         // run_last
    logic [1:0]        m_axis_tuser;         // stream_done, length_error

    dir_t               cur_dir    = DIR_PACK;
    logic [BLOCK_W-1:0] block_bits = '0;
    logic [CNT_W-1:0]   block_cnt  = '0;
    regroup_t           pending_results[$];
    stim_row_t          plan [PLAN_N];

    int       n_mismatches = 0;
    int       n_items      = 0;
    int       n_results    = 0;
    int       n_len_errors = 0;
    int       n_dir_writes = 0;
    int       burst_left   = 0;
    bit       gapless      = 1'b0;
    bit       hold_req     = 1'b0;
    int       hold_left    = 0;
    int       mode_left    = 0;
    rx_mode_t rx_mode      = RX_OPEN;

    byte_quint_regrouper i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic regroup_t mk_result(logic [BYTE_W-1:0] v, logic l, logic d, logic e);
        regroup_t r;
        r.value = v;
        r.last  = l;
        r.done  = d;
        r.err   = e;
        return r;
    endfunction

    function automatic stim_row_t item_row(logic [BYTE_W-1:0] v, logic e);
        stim_row_t r;
        r        = '0;
        r.value  = v;
        r.eos    = e;
        return r;
    endfunction

    function automatic stim_row_t error_row(logic [BYTE_W-1:0] v);
        stim_row_t r;
        r        = item_row(v, 1'b1);
        r.typed  = 1'b1;
        r.want   = mk_result(8'h00, 1'b1, 1'b1, 1'b1);
        return r;
    endfunction

    function automatic stim_row_t dir_row(dir_t d);
        stim_row_t r;
        r        = '0;
        r.wr_dir = 1'b1;
        r.value  = BYTE_W'(d);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
        $display("mismatch in %s at result %0d: got %0h, expected %0h",
                 field, n_results, got, want);
        n_mismatches++;
    endtask

    task automatic predict_regroup(input logic [BYTE_W-1:0] v, input logic e,
                                   output regroup_t outs[$]);
        logic [BLOCK_W-1:0] padded;
        outs = {};
        if (cur_dir == DIR_PACK) begin
            block_bits = {block_bits[BLOCK_W-BYTE_W-1:0], v};
            block_cnt  = block_cnt + 1'b1;
            if (block_cnt >= CNT_W'(BYTES_PER_BLOCK)) begin
                for (int k = 0; k < SYMS_PER_BLOCK; k++) begin
                    outs = {outs, mk_result(BYTE_W'(block_bits[BLOCK_W-1-SYM_W*k -: SYM_W]),
                                            k == SYMS_PER_BLOCK - 1,
                                            e && k == SYMS_PER_BLOCK - 1, 1'b0)};
                end
                block_bits = '0;
                block_cnt  = '0;
            end else if (e) begin
                outs = {outs, mk_result(8'h00, 1'b1, 1'b1, 1'b1)};
                block_bits = '0;
                block_cnt  = '0;
            end
        end else begin
            block_bits = {block_bits[BLOCK_W-SYM_W-1:0], v[SYM_W-1:0]};
            block_cnt  = block_cnt + 1'b1;
            if (block_cnt == '0 || e) begin
                padded = block_bits;
                if (block_cnt != '0) begin
                    padded = block_bits << (SYM_W * (SYMS_PER_BLOCK - block_cnt));
                end
                for (int k = 0; k < BYTES_PER_BLOCK; k++) begin
                    outs = {outs, mk_result(padded[BLOCK_W-1-BYTE_W*k -: BYTE_W],
                                            k == BYTES_PER_BLOCK - 1,
                                            e && k == BYTES_PER_BLOCK - 1, 1'b0)};
                end
                block_bits = '0;
                block_cnt  = '0;
            end
        end
    endtask

    task automatic send_item(input logic [BYTE_W-1:0] v, input logic e, input bit typed,
                             input regroup_t want);
        regroup_t outs[$];
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = gapless ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= e;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        n_items++;
        predict_regroup(v, e, outs);
        if (typed) begin
            pending_results = {pending_results, want};
        end else begin
            pending_results = {pending_results, outs};
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_direction(dir_t d);
        drain_results();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= d;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_dir    = d;
        block_bits = '0;
        block_cnt  = '0;
        n_dir_writes++;
    endtask

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= (mode_left % 4 == 0);
                default:   m_axis_tready <= ($urandom_range(0, 6) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        regroup_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (m_axis_tuser[1]) n_len_errors++;
            if (pending_results.size() == 0) begin
                report_mismatch("transaction with nothing pending", m_axis_tdata, 8'h00);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.value)
                    report_mismatch("result_value", m_axis_tdata, want.value);
                if (m_axis_tlast !== want.last)
                    report_mismatch("run_last", BYTE_W'(m_axis_tlast), BYTE_W'(want.last));
                if (m_axis_tuser[0] !== want.done)
                    report_mismatch("stream_done", BYTE_W'(m_axis_tuser[0]), BYTE_W'(want.done));
                if (m_axis_tuser[1] !== want.err)
                    report_mismatch("length_error", BYTE_W'(m_axis_tuser[1]), BYTE_W'(want.err));
            end
        end
    end

    initial begin
        #2ms;
        $display("timeout: transactions stalled");
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int                len;
        int                phase_items;
        bit                ends;
        bit                paused;
        logic [BYTE_W-1:0] v;

        plan = '{
            // pack: one full block, then short streams, then a block ending the stream
            item_row(8'h00, 1'b0), item_row(8'hff, 1'b0), item_row(8'h80, 1'b0),
            item_row(8'h01, 1'b0), item_row(8'haa, 1'b0),
            item_row(8'h12, 1'b0), error_row(8'h34),
            error_row(8'hff),
            item_row(8'hff, 1'b0), item_row(8'hff, 1'b0), item_row(8'hff, 1'b0),
            item_row(8'hff, 1'b0), item_row(8'hff, 1'b1),
            dir_row(DIR_UNPACK),
            // unpack: full block with upper bits set, then padded partial blocks
            item_row(8'h1f, 1'b0), item_row(8'he0, 1'b0), item_row(8'hff, 1'b0),
            item_row(8'h00, 1'b0), item_row(8'h15, 1'b0), item_row(8'h0a, 1'b0),
            item_row(8'h1f, 1'b0), item_row(8'h1f, 1'b0),
            item_row(8'hff, 1'b0), item_row(8'h01, 1'b0), item_row(8'h10, 1'b1),
            item_row(8'h1f, 1'b1)
        };
        paused = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].wr_dir) begin
                write_direction(dir_t'(plan[i].value[0]));
            end else begin
                send_item(plan[i].value, plan[i].eos, plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            write_direction(ph < 4 ? dir_t'(ph[0]) : dir_t'($urandom_range(0, 1)));
            gapless = (ph == 2);
            if (ph == 1) hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if (cur_dir == DIR_PACK) begin
                    len = BYTES_PER_BLOCK * $urandom_range(1, 3);
                    if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 14);
                end else begin
                    len = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) == 0) len = SYMS_PER_BLOCK * $urandom_range(1, 2);
                end
                // some streams run on without an end mark
                ends = ($urandom_range(0, 7) != 0);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 9))
                        0:       v = 8'h00;
                        1:       v = 8'hff;
                        default: v = BYTE_W'($urandom_range(0, 255));
                    endcase
                    send_item(v, ends && i == len - 1, 1'b0, '0);
                end
                phase_items += len;
                if (ph == 3 && !paused) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        $display("covered %0d input transactions over %0d direction writes in both modes",
                 n_items, n_dir_writes);
        $display("checked %0d results, %0d of them length errors, %0d mismatches",
                 n_results, n_len_errors, n_mismatches);
        if (n_mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[byte_quint_regrouper.f]
rtl/brq_pkg.sv
rtl/brq_front.sv
rtl/brq_queue.sv
rtl/brq_back.sv
rtl/byte_quint_regrouper.sv
verif/byte_quint_regrouper_test.sv
